[sv/stereo_block_match_disparity_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef STEREO_BLOCK_MATCH_DISPARITY_CORE_MACROS_SVH
`define STEREO_BLOCK_MATCH_DISPARITY_CORE_MACROS_SVH

// Clocked assertion, off while reset is held
`define BSMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs during reset
`define BSMD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bsmd_pkg.sv]
// ----------------------------------------------------------------------------
// bsmd_pkg
// Shared types and constants of the stereo block-matching disparity core.
// ----------------------------------------------------------------------------
package bsmd_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 11;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_WIN_HALF   = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_MAX_DISP   = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_COST_MODE  = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_LINE_WIDTH = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } state_t;

  // Control broadcast to every disparity cell
  typedef struct packed {
    logic feed;    // new left/right pair present, shift right pixel
    logic acc_en;  // pair lies inside the window columns
    logic clr;     // clear cost accumulators
    logic drain;   // shift accumulators toward cell 0
    logic sad;     // 1 absolute difference, 0 squared difference
  } cell_ctrl_t;

endpackage

[sv/bsmd_ram.sv]
// ----------------------------------------------------------------------------
// bsmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/bsmd_cell.sv]
// ----------------------------------------------------------------------------
// bsmd_cell
// One disparity cell: delays the right pixel by one step and accumulates the
// matching cost of its disparity; accumulators drain toward cell 0.
// ----------------------------------------------------------------------------
module bsmd_cell #(
  parameter int AW = 26
) (
  input  logic                    clk,
  input  bsmd_pkg::cell_ctrl_t    ctrl,
  input  logic [bsmd_pkg::PIX_W-1:0] l_pix,
  input  logic [bsmd_pkg::PIX_W-1:0] r_in,
  output logic [bsmd_pkg::PIX_W-1:0] r_out,
  input  logic [AW-1:0]           acc_in,
  output logic [AW-1:0]           acc_out
);

  logic [bsmd_pkg::PIX_W-1:0]   r_r;
  logic [AW-1:0]                acc_r;
  logic [bsmd_pkg::PIX_W-1:0]   adiff;
  logic [2*bsmd_pkg::PIX_W-1:0] sq;
  logic [AW-1:0]                term;

  // Pixel cost
  always_comb begin
    adiff = (l_pix >= r_in) ? l_pix - r_in : r_in - l_pix;
    sq    = adiff * adiff;
    term  = ctrl.sad ? AW'(adiff) : AW'(sq);
  end

  // Shift right pixel, accumulate or drain cost
  always_ff @(posedge clk) begin
    if (ctrl.feed) begin
      r_r <= r_in;
    end
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.drain) begin
      acc_r <= acc_in;
    end else if (ctrl.feed && ctrl.acc_en) begin
      acc_r <= acc_r + term;
    end
  end

  assign r_out   = r_r;
  assign acc_out = acc_r;

endmodule

[sv/stereo_block_match_disparity_core.sv]
// ----------------------------------------------------------------------------
// stereo_block_match_disparity_core
// Stereo block matching (SAD or SSD) with line stores and a disparity chain.
// ----------------------------------------------------------------------------
// Each pixel pair is written to a combined left/right line store. A pixel
// with no result is stored without stalling the input. A pixel that
// completes a window, searching disparities up to the configured limit, holds
// off the input until its result enters the output register, also while
// the previous result still waits there: the window rows are streamed once
// from the single read port of the line store through a chain of disparity
// cells, the cell costs are drained and compared one per cycle, and the
// scaling divide runs one quotient bit per cycle. Border pixels give no result.
module stereo_block_match_disparity_core #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_HEIGHT    = 1024,
  parameter int MAX_WINDOW    = 31,
  parameter int MAX_DISPARITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // left_pix[7:0], right_pix[15:8]
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // disparity[7:0], out_col[17:8], out_row[27:18]
  input  logic        cfg_we,
  input  logic [bsmd_pkg::CFG_A_W-1:0] cfg_addr,
  input  logic [bsmd_pkg::CFG_D_W-1:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = $clog2(MAX_HEIGHT + 1);
  localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HMAX  = (MAX_WINDOW - 1) / 2;
  localparam int NC    = MAX_DISPARITY + 1;
  localparam int DMW   = $clog2(MAX_DISPARITY + 1);
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int ADW   = $clog2(DEPTH);
  localparam int AW    = $clog2(MAX_WINDOW * MAX_WINDOW * 65025 + 1);
  localparam int EW    = (CW > 11) ? CW : 11;
  localparam int XW    = (CW > 8) ? CW : 8;

  // Configuration registers
  logic [3:0]  win_half_r;
  logic [6:0]  max_disp_r;
  logic        sad_r;
  logic [10:0] line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_half_r   <= 4'd3;
      max_disp_r   <= 7'd64;
      sad_r        <= 1'b1;
      line_width_r <= 11'd640;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bsmd_pkg::CFG_WIN_HALF:   win_half_r   <= cfg_wdata[3:0];
        bsmd_pkg::CFG_MAX_DISP:   max_disp_r   <= cfg_wdata[6:0];
        bsmd_pkg::CFG_COST_MODE:  sad_r        <= cfg_wdata[0];
        bsmd_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_wdata[10:0];
      endcase
    end
  end

  // Saturated configuration
  logic [CW-1:0] width_eff;
  logic [3:0]    h_eff;
  logic [4:0]    h2;
  logic [6:0]    md_eff;

  always_comb begin
    if (line_width_r == 11'd0) begin
      width_eff = CW'(1);
    end else if (EW'(line_width_r) > EW'(MAX_WIDTH)) begin
      width_eff = CW'(MAX_WIDTH);
    end else begin
      width_eff = CW'(line_width_r);
    end
    h_eff  = (32'(win_half_r) > HMAX) ? 4'(HMAX) : win_half_r;
    h2     = {h_eff, 1'b0};
    md_eff = (32'(max_disp_r) > MAX_DISPARITY) ? 7'(MAX_DISPARITY) : max_disp_r;
  end

  // State
  bsmd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic           done_r, done_nxt;

  logic [CW-1:0]  c_start_r, c_start_nxt;
  logic [CW-1:0]  c_lo_r, c_lo_nxt;
  logic [CW-1:0]  c_hi_r, c_hi_nxt;
  logic [CW-1:0]  x_r, x_nxt;
  logic [RW-1:0]  y_r, y_nxt;
  logic [DMW-1:0] dmax_r, dmax_nxt;
  logic [6:0]     md_r, md_nxt;
  logic [4:0]     h2_r, h2_nxt;

  logic [CW-1:0]  cs_r, cs_nxt;
  logic [4:0]     ri_r, ri_nxt;
  logic [SW-1:0]  slc_r, slc_nxt;
  logic           feed_d1_r, feed_d1_nxt;
  logic           acc_en_d1_r, acc_en_d1_nxt;

  logic [DMW-1:0] k_r, k_nxt;
  logic [DMW-1:0] best_r, best_nxt;
  logic [AW-1:0]  best_cost_r, best_cost_nxt;

  logic [15:0]    num_r, num_nxt;
  logic [6:0]     rem_r, rem_nxt;
  logic [4:0]     step_r, step_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [27:0]    out_data_r, out_data_nxt;

  // Memory and chain signals
  logic            ram_we;
  logic [ADW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]     ram_rdata;
  bsmd_pkg::cell_ctrl_t ctrl;
  logic [bsmd_pkg::PIX_W-1:0] r_link [NC+1];
  logic [AW-1:0]   acc_link [NC+1];

  // Combinational work variables
  logic           in_acc;
  logic [CW-1:0]  cc, wcol;
  logic [RW-1:0]  rc, wrow;
  logic [SW-1:0]  sl, wsl;
  logic           dn, take, emit;
  logic [XW-1:0]  xd, mdx, dsel;
  logic [7:0]     rem_t;
  logic [AW-1:0]  cost0;

  assign in_acc = in_tvalid && in_tready;
  assign cost0  = acc_link[0];

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    slot_nxt      = slot_r;
    done_nxt      = done_r;
    c_start_nxt   = c_start_r;
    c_lo_nxt      = c_lo_r;
    c_hi_nxt      = c_hi_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dmax_nxt      = dmax_r;
    md_nxt        = md_r;
    h2_nxt        = h2_r;
    cs_nxt        = cs_r;
    ri_nxt        = ri_r;
    slc_nxt       = slc_r;
    feed_d1_nxt   = 1'b0;
    acc_en_d1_nxt = 1'b0;
    k_nxt         = k_r;
    best_nxt      = best_r;
    best_cost_nxt = best_cost_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = ADW'(slc_r) * ADW'(MAX_WIDTH) + ADW'(cs_r);
    ctrl.feed     = feed_d1_r;
    ctrl.acc_en   = acc_en_d1_r;
    ctrl.clr      = 1'b0;
    ctrl.drain    = 1'b0;
    ctrl.sad      = sad_r;
    cc            = col_r;
    rc            = row_r;
    sl            = slot_r;
    dn            = done_r;
    take          = 1'b0;
    emit          = 1'b0;
    wcol          = '0;
    wrow          = '0;
    wsl           = '0;
    xd            = '0;
    mdx           = '0;
    dsel          = '0;
    rem_t         = '0;

    unique case (state_r)
      bsmd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          // Frame restart, row wrap and frame end before the pixel is taken
          if (in_tuser) begin
            cc = '0;
            rc = '0;
            sl = '0;
            dn = 1'b0;
          end
          if (!dn && cc >= width_eff) begin
            cc = '0;
            rc = rc + 1'b1;
            sl = (sl == SW'(MAX_WINDOW - 1)) ? '0 : sl + 1'b1;
            if (rc >= RW'(MAX_HEIGHT)) begin
              dn = 1'b1;
            end
          end
          if (!dn) begin
            take = 1'b1;
            wcol = cc;
            wrow = rc;
            wsl  = sl;
            emit = (wrow >= RW'(h2)) && (wcol >= CW'(h2));
            cc   = cc + 1'b1;
            if (cc >= width_eff) begin
              cc = '0;
              rc = rc + 1'b1;
              sl = (sl == SW'(MAX_WINDOW - 1)) ? '0 : sl + 1'b1;
              if (rc >= RW'(MAX_HEIGHT)) begin
                dn = 1'b1;
              end
            end
          end
          col_nxt  = cc;
          row_nxt  = rc;
          slot_nxt = sl;
          done_nxt = dn;
          // Store the pair
          ram_we    = take;
          ram_waddr = ADW'(wsl) * ADW'(MAX_WIDTH) + ADW'(wcol);
          // Set up the window search
          if (emit) begin
            xd          = XW'(wcol) - XW'(h2);
            mdx         = XW'(md_eff);
            dsel        = (xd < mdx) ? xd : mdx;
            dmax_nxt    = DMW'(dsel);
            c_lo_nxt    = CW'(xd);
            c_start_nxt = CW'(xd - dsel);
            cs_nxt      = CW'(xd - dsel);
            c_hi_nxt    = wcol;
            x_nxt       = wcol - CW'(h_eff);
            y_nxt       = wrow - RW'(h_eff);
            md_nxt      = md_eff;
            h2_nxt      = h2;
            ri_nxt      = '0;
            slc_nxt     = (wsl >= SW'(h2)) ? wsl - SW'(h2)
                                           : SW'(wsl + SW'(MAX_WINDOW) - SW'(h2));
            ctrl.clr    = 1'b1;
            state_nxt   = bsmd_pkg::ST_READ;
          end
        end
      end

      bsmd_pkg::ST_READ: begin
        // Stream one window row per pass through the chain
        feed_d1_nxt   = 1'b1;
        acc_en_d1_nxt = (cs_r >= c_lo_r);
        if (cs_r == c_hi_r) begin
          cs_nxt  = c_start_r;
          ri_nxt  = ri_r + 1'b1;
          slc_nxt = (slc_r == SW'(MAX_WINDOW - 1)) ? '0 : slc_r + 1'b1;
          if (ri_r == h2_r) begin
            state_nxt = bsmd_pkg::ST_WAIT;
          end
        end else begin
          cs_nxt = cs_r + 1'b1;
        end
      end

      bsmd_pkg::ST_WAIT: begin
        // Last read data enters the chain
        k_nxt     = '0;
        state_nxt = bsmd_pkg::ST_SCAN;
      end

      bsmd_pkg::ST_SCAN: begin
        // Drain costs one per cycle, keep the earliest minimum
        ctrl.drain = 1'b1;
        if (k_r == '0 || cost0 < best_cost_r) begin
          best_cost_nxt = cost0;
          best_nxt      = k_r;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == dmax_r) begin
          state_nxt = bsmd_pkg::ST_PREP;
        end
      end

      bsmd_pkg::ST_PREP: begin
        num_nxt   = 16'(best_r) * 16'd255;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = bsmd_pkg::ST_DIV;
      end

      bsmd_pkg::ST_DIV: begin
        // Restoring divide, one quotient bit per cycle
        rem_t = {rem_r, num_r[15]};
        if (rem_t >= {1'b0, md_r}) begin
          rem_nxt = 7'(rem_t - {1'b0, md_r});
          num_nxt = {num_r[14:0], 1'b1};
        end else begin
          rem_nxt = rem_t[6:0];
          num_nxt = {num_r[14:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd15) begin
          state_nxt = bsmd_pkg::ST_HOLD;
        end
      end

      bsmd_pkg::ST_HOLD: begin
        // Load the output register once it is free
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {10'(y_r), 10'(x_r), (md_r == '0) ? 8'd0 : num_r[7:0]};
          state_nxt     = bsmd_pkg::ST_IDLE;
        end
      end

      default: state_nxt = bsmd_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsmd_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      slot_r      <= '0;
      done_r      <= 1'b0;
      feed_d1_r   <= 1'b0;
      acc_en_d1_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      slot_r      <= slot_nxt;
      done_r      <= done_nxt;
      feed_d1_r   <= feed_d1_nxt;
      acc_en_d1_r <= acc_en_d1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_start_r   <= c_start_nxt;
    c_lo_r      <= c_lo_nxt;
    c_hi_r      <= c_hi_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    dmax_r      <= dmax_nxt;
    md_r        <= md_nxt;
    h2_r        <= h2_nxt;
    cs_r        <= cs_nxt;
    ri_r        <= ri_nxt;
    slc_r       <= slc_nxt;
    k_r         <= k_nxt;
    best_r      <= best_nxt;
    best_cost_r <= best_cost_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    out_data_r  <= out_data_nxt;
  end

  // Combined left/right line store
  bsmd_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Disparity cell chain
  assign r_link[0]    = ram_rdata[15:8];
  assign acc_link[NC] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    bsmd_cell #(
      .AW (AW)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .l_pix   (ram_rdata[7:0]),
      .r_in    (r_link[g]),
      .r_out   (r_link[g+1]),
      .acc_in  (acc_link[g+1]),
      .acc_out (acc_link[g])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};

endmodule

[sv/bsmd_checker.sv]
// ----------------------------------------------------------------------------
// bsmd_checker
// Port-level checks of the stereo block-matching disparity core.
// ----------------------------------------------------------------------------
`include "stereo_block_match_disparity_core_macros.svh"

module bsmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // No result directly after reset
  `BSMD_ASSERT_ALWAYS(a_no_out_after_rst, !$past(rst_n) |-> !out_tvalid, "result valid after reset")

  // The output register is reloaded only while empty, so a taken transaction leaves a gap
  `BSMD_ASSERT(a_gap_after_out, out_tvalid && out_tready |=> !out_tvalid, "back-to-back results")

  // Hold a stalled result
  `BSMD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind stereo_block_match_disparity_core bsmd_checker u_bsmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
